[rtl/core/pulse_period_qualified_counter_core_macros.svh]
// Assertion macros for the pulse period qualified counter core.
// Expects clk and rst_n in the scope of each use.
`ifndef PULSE_PERIOD_QUALIFIED_COUNTER_CORE_MACROS_SVH
`define PULSE_PERIOD_QUALIFIED_COUNTER_CORE_MACROS_SVH

// Same-cycle implication.
`define PPQC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PPQC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ppqc_pkg.sv]
// Shared types and codes for the pulse period qualified counter core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppqc_pkg;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [1:0] {
    ACT_MEASURE = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_LOAD    = 2'd2,
    ACT_READ    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CLR_SLOW = 2'd0,
    CLR_FAST = 2'd1,
    CLR_BOTH = 2'd2,
    CLR_NONE = 2'd3
  } clear_sel_t;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_DONE    = 2'd1;
  localparam logic [1:0] ST_NOT_ENABLED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_PER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_FACT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_LIMIT = 3'd6;

  typedef struct packed {
    logic        counting_enabled;
    logic [31:0] min_period;
    logic [31:0] max_period;
    logic [31:0] corr_period;
    logic [7:0]  corr_factor;
    logic [7:0]  fast_filter_limit;
    logic [7:0]  slow_filter_limit;
  } cfg_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] period;
    logic        measure_ok;
    clear_sel_t  clear_select;
    logic [15:0] new_count;
  } item_t;

  typedef struct packed {
    logic [15:0] pulse_count;
    logic [1:0]  warnings;
    logic [1:0]  status;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/ppqc_update.sv]
// Counter state registers and single-pass update logic.
// Depends on ppqc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppqc_update (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              fire,
  input  ppqc_pkg::item_t  item,
  input  ppqc_pkg::cfg_t   cfg,
  output ppqc_pkg::result_t res
);
  import ppqc_pkg::*;

  logic [15:0] count_r, count_nxt;
  logic [7:0]  fast_cnt_r, fast_cnt_nxt;
  logic [7:0]  slow_cnt_r, slow_cnt_nxt;
  logic [7:0]  corr_cnt_r, corr_cnt_nxt;
  logic        fast_warn_r, fast_warn_nxt;
  logic        slow_warn_r, slow_warn_nxt;
  logic [1:0]  status;
  logic [7:0]  corr_inc;
  logic [15:0] count_inc;

  always_comb begin
    count_nxt     = count_r;
    fast_cnt_nxt  = fast_cnt_r;
    slow_cnt_nxt  = slow_cnt_r;
    corr_cnt_nxt  = corr_cnt_r;
    fast_warn_nxt = fast_warn_r;
    slow_warn_nxt = slow_warn_r;
    status        = ST_OK;
    corr_inc      = corr_cnt_r + 8'd1;
    count_inc     = count_r + 16'd1;
    case (item.action)
      ACT_MEASURE: begin
        if (!item.measure_ok) begin
          status = ST_NOT_DONE;
        end else if (!cfg.counting_enabled) begin
          status = ST_NOT_ENABLED;
        end else if (item.period < cfg.min_period) begin
          if (fast_cnt_r < cfg.fast_filter_limit) fast_cnt_nxt = fast_cnt_r + 8'd1;
          else fast_warn_nxt = 1'b1;
        end else if (item.period > cfg.max_period) begin
          if (slow_cnt_r < cfg.slow_filter_limit) slow_cnt_nxt = slow_cnt_r + 8'd1;
          else slow_warn_nxt = 1'b1;
        end else begin
          fast_cnt_nxt = '0;
          slow_cnt_nxt = '0;
          count_nxt    = count_inc;
          if (item.period >= cfg.corr_period) begin
            if (corr_inc >= cfg.corr_factor) begin
              corr_cnt_nxt = '0;
              count_nxt    = count_r + 16'd2;
            end else begin
              corr_cnt_nxt = corr_inc;
            end
          end else begin
            corr_cnt_nxt = '0;
          end
        end
      end
      ACT_CLEAR: begin
        if (item.clear_select == CLR_SLOW || item.clear_select == CLR_BOTH) begin
          slow_cnt_nxt  = '0;
          slow_warn_nxt = 1'b0;
        end
        if (item.clear_select == CLR_FAST || item.clear_select == CLR_BOTH) begin
          fast_cnt_nxt  = '0;
          fast_warn_nxt = 1'b0;
        end
      end
      ACT_LOAD: begin
        count_nxt = item.new_count;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      fast_cnt_r  <= '0;
      slow_cnt_r  <= '0;
      corr_cnt_r  <= '0;
      fast_warn_r <= 1'b0;
      slow_warn_r <= 1'b0;
    end else if (fire) begin
      count_r     <= count_nxt;
      fast_cnt_r  <= fast_cnt_nxt;
      slow_cnt_r  <= slow_cnt_nxt;
      corr_cnt_r  <= corr_cnt_nxt;
      fast_warn_r <= fast_warn_nxt;
      slow_warn_r <= slow_warn_nxt;
    end
  end

  assign res.pulse_count = count_nxt;
  assign res.warnings    = {slow_warn_nxt, fast_warn_nxt};
  assign res.status      = status;

endmodule

`default_nettype wire

[rtl/core/pulse_period_qualified_counter_core.sv]
// Pulse period qualified counter: top level with config registers,
// input register and result register. Depends on ppqc_pkg, ppqc_update
// and pulse_period_qualified_counter_core_macros.svh.
//
// Usage:
//  - in_* stream carries one action per transfer (measure, clear warnings,
//    load count, read). in_tuser holds the action code.
//  - out_* stream returns exactly one result per input transfer, in order:
//    pulse count, warning flags and status after that action.
//  - cfg_* writes one setting per cycle while cfg_we is high; write only
//    while no transfer is in flight.
//  - A result passes the input register, then the result register, before
//    it is presented. Throughput is one transfer per cycle while out_tready
//    is high, set by the state update between the two registers.
//  - When out_tready is low the result register holds; one more item can
//    wait in the input register, after which in_tready drops.
//  - Reset (rst_n low, synchronous) empties both registers, clears the
//    counters and warnings, and loads the default settings.
`timescale 1ns / 1ps
`default_nettype none

module pulse_period_qualified_counter_core (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // [31:0] period, [32] measure_ok, [34:33] clear_select, [50:35] new_count
  input  wire  [ppqc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] action
  input  wire  [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // [15:0] pulse_count, [17:16] warnings, [19:18] status
  output logic [ppqc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  wire                                cfg_we,
  input  wire  [ppqc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [ppqc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ppqc_pkg::*;

  cfg_t    cfg_r;
  logic    in_v_r;
  item_t   in_item_r;
  logic    out_v_r;
  result_t out_res_r;
  result_t res;
  logic    adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.counting_enabled  <= 1'b0;
      cfg_r.min_period        <= '0;
      cfg_r.max_period        <= '1;
      cfg_r.corr_period       <= '1;
      cfg_r.corr_factor       <= 8'd255;
      cfg_r.fast_filter_limit <= 8'd3;
      cfg_r.slow_filter_limit <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:     cfg_r.counting_enabled  <= cfg_wdata[0];
        REG_MIN_PERIOD: cfg_r.min_period        <= cfg_wdata;
        REG_MAX_PERIOD: cfg_r.max_period        <= cfg_wdata;
        REG_CORR_PER:   cfg_r.corr_period       <= cfg_wdata;
        REG_CORR_FACT:  cfg_r.corr_factor       <= cfg_wdata[7:0];
        REG_FAST_LIMIT: cfg_r.fast_filter_limit <= cfg_wdata[7:0];
        REG_SLOW_LIMIT: cfg_r.slow_filter_limit <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.action       <= action_t'(in_tuser);
      in_item_r.period       <= in_tdata[31:0];
      in_item_r.measure_ok   <= in_tdata[32];
      in_item_r.clear_select <= clear_sel_t'(in_tdata[34:33]);
      in_item_r.new_count    <= in_tdata[50:35];
    end
  end

  ppqc_update u_update (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_res_r.status, out_res_r.warnings, out_res_r.pulse_count};

`include "pulse_period_qualified_counter_core_macros.svh"

  `PPQC_ASSERT_IMP(a_status_code, out_v_r, out_res_r.status != 2'd3, "bad status code")
  `PPQC_ASSERT_NXT(a_fill, in_v_r && !out_v_r, out_v_r, "held item not moved to output")
  `PPQC_ASSERT_NXT(a_load, adv && in_item_r.action == ACT_LOAD,
                   out_res_r.pulse_count == $past(in_item_r.new_count), "load count lost")

endmodule

`default_nettype wire
